// ----- src/matrix3_inverse_transpose_assert.svh -----
// ---------------------------------------------------------------------------
// matrix3_inverse_transpose_assert.svh - assertion macros
// Concurrent assertion forms used by mit_fifo, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_TRANSPOSE_ASSERT_SVH
`define MATRIX3_INVERSE_TRANSPOSE_ASSERT_SVH

// same-cycle implication
`define MIT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/mit_pkg.sv -----
// ---------------------------------------------------------------------------
// mit_pkg - shared types and constants
// Widths, minor index tables and the job word passed from front to back.
// ---------------------------------------------------------------------------
package mit_pkg;

    localparam int ELEM_W = 32;
    localparam int NE     = 9;
    localparam int DATA_W = NE * ELEM_W;
    localparam int COF_W  = 48;
    localparam int DET_W  = 64;
    localparam int USER_W = 2;
    localparam int USER_SING = 0;
    localparam int USER_SAT  = 1;
    localparam int DIV_STG   = ELEM_W;

    localparam logic signed [DET_W-1:0] Q_ONE = 64'sd65536;

    // minor k = a[X]*a[Y] - a[Z]*a[W], elements indexed row-major from 0
    localparam int unsigned MIN_X [NE] = '{4, 6, 3, 7, 0, 6, 1, 3, 0};
    localparam int unsigned MIN_Y [NE] = '{8, 5, 7, 2, 8, 1, 5, 2, 4};
    localparam int unsigned MIN_Z [NE] = '{7, 3, 6, 1, 6, 0, 4, 0, 3};
    localparam int unsigned MIN_W [NE] = '{5, 8, 4, 8, 2, 7, 2, 5, 1};

    typedef struct packed {
        logic [NE-1:0][COF_W-1:0] cof;
        logic [DET_W-1:0]         det;
    } t_job;

endpackage

// ----- src/matrix3_inverse_transpose.sv -----
// ---------------------------------------------------------------------------
// matrix3_inverse_transpose - 3x3 inverse transpose, signed Q16.16
// Cofactor matrix divided by the determinant, with singular and clamp flags.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream takes one matrix per word: nine signed Q16.16 elements,
//   a11 in the lowest 32 bits up to a33 in the highest. Master stream
//   returns one word per matrix: r11..r33 in the same layout, with the
//   singular and saturated flags in tuser.
//   A word passes through a six-stage front (products, cofactors,
//   determinant), a short job queue, and a back end of nine parallel
//   restoring dividers, one quotient bit per stage. Throughput is one
//   matrix per cycle while the receiver holds tready high; the 32-stage
//   divider lanes set the latency, the queue decouples front from back.
//   When the receiver drops tready the back end and output register
//   hold; the front keeps going until the queue fills, then deasserts
//   o_s_axis_tready. Reset empties all pipelines and the queue; there
//   is no other state.
//   A zero determinant divides by one and sets singular; any lane that
//   leaves the 32-bit range clamps and sets saturated.
// ---------------------------------------------------------------------------
module matrix3_inverse_transpose import mit_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // a11, a12, a13, a21, a22, a23, a31, a32, a33 (32 bits each)
    input  logic [DATA_W-1:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33 (32 bits each)
    output logic [DATA_W-1:0] o_m_axis_tdata,
    // singular, saturated
    output logic [USER_W-1:0] o_m_axis_tuser
);

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job job_in;
    t_job job_out;

    // front: accept words, build cofactors and determinant
    mit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    // queue: absorb back-end stalls
    mit_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (job_out)
    );

    // back: divide, clamp, drive the master stream
    mit_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (pop),
        .i_job    (job_out),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

// ----- src/mit_front.sv -----
// ---------------------------------------------------------------------------
// mit_front - cofactor and determinant pipeline
// Six stages: products, cofactors, split products, terms, two-step sum.
// ---------------------------------------------------------------------------
module mit_front import mit_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_full
);

    logic                     en;
    logic [6:1]               r_v;
    logic signed [31:0]       w_a [NE];
    logic signed [63:0]       r_pxy [NE];
    logic signed [63:0]       r_pzw [NE];
    logic signed [63:0]       w_minor [NE];
    logic signed [31:0]       r_a1 [3];
    logic signed [31:0]       r_a2 [3];
    logic signed [COF_W-1:0]  r_cof [2:6][NE];
    logic signed [63:0]       r_mh [3];
    logic signed [48:0]       r_ml [3];
    logic signed [63:0]       r_t [3];
    logic signed [63:0]       r_s12;
    logic signed [63:0]       r_t3;
    logic signed [64:0]       w_sum;
    logic signed [63:0]       w_det;
    logic signed [63:0]       r_det;

    assign en      = !r_v[6] || !i_full;
    assign o_ready = en;
    assign o_push  = r_v[6] && !i_full;

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            w_a[k]     = i_data[ELEM_W*k +: ELEM_W];
            w_minor[k] = r_pxy[k] - r_pzw[k];
        end
        w_sum = {r_s12[63], r_s12} + {r_t3[63], r_t3};
        if (w_sum[64] != w_sum[63]) begin
            w_det = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_det = w_sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NE; k++) begin
                r_pxy[k]    <= w_a[MIN_X[k]] * w_a[MIN_Y[k]];
                r_pzw[k]    <= w_a[MIN_Z[k]] * w_a[MIN_W[k]];
                // floor by 2^16 is the upper bits of the exact minor
                r_cof[2][k] <= w_minor[k][63:16];
            end
            for (int j = 0; j < 3; j++) begin
                r_a1[j] <= w_a[j];
                r_a2[j] <= r_a1[j];
                r_mh[j] <= r_a2[j] * $signed(r_cof[2][j][47:16]);
                r_ml[j] <= r_a2[j] * $signed({1'b0, r_cof[2][j][15:0]});
                r_t[j]  <= r_mh[j] + {{31{r_ml[j][48]}}, r_ml[j][48:16]};
            end
            for (int s = 3; s <= 6; s++) begin
                r_cof[s] <= r_cof[s-1];
            end
            r_s12 <= r_t[0] + r_t[1];
            r_t3  <= r_t[2];
            r_det <= w_det;
        end
    end

    always_comb begin
        o_job.det = r_det;
        for (int k = 0; k < NE; k++) begin
            o_job.cof[k] = r_cof[6][k];
        end
    end

endmodule

// ----- src/mit_fifo.sv -----
// ---------------------------------------------------------------------------
// mit_fifo - job queue between front and back
// Register-based FIFO; head word read combinationally.
// ---------------------------------------------------------------------------
`include "matrix3_inverse_transpose_assert.svh"

module mit_fifo import mit_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `MIT_ASSERT_NEXT(a_cnt_up, push && !pop, r_count == $past(r_count) + 1'b1)
    `MIT_ASSERT_NEXT(a_cnt_dn, pop && !push, r_count == $past(r_count) - 1'b1)
    `MIT_ASSERT_NOW(a_ptr_gap, r_count == '0 || r_count == CW'(DEPTH), r_wr == r_rd)

endmodule

// ----- src/mit_back.sv -----
// ---------------------------------------------------------------------------
// mit_back - nine-lane pipelined divider and output register
// One quotient bit per stage per lane, then sign, clamp and flags.
// ---------------------------------------------------------------------------
module mit_back import mit_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_pop,
    input  t_job              i_job,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata,
    output logic [USER_W-1:0] o_tuser
);

    logic                    en;
    logic [DIV_STG:0]        r_v;
    logic [63:0]             r_dv   [DIV_STG+1];
    logic                    r_sing [DIV_STG+1];
    logic [63:0]             r_rem  [DIV_STG+1][NE];
    logic [31:0]             r_quo  [DIV_STG+1][NE];
    logic                    r_neg  [DIV_STG+1][NE];
    logic                    r_ovf  [DIV_STG+1][NE];
    logic [63:0]             n_rem  [DIV_STG+1][NE];
    logic [31:0]             n_quo  [DIV_STG+1][NE];

    logic signed [63:0]      w_det;
    logic signed [63:0]      w_div;
    logic [63:0]             w_dv;
    logic [63:0]             w_num  [NE];
    logic [63:0]             w_n    [NE];
    logic [NE-1:0]           w_neg;
    logic [NE-1:0]           w_ovf;

    logic [DATA_W-1:0]       n_data;
    logic [NE-1:0]           n_sat;
    logic                    r_ov;
    logic [DATA_W-1:0]       r_data;
    logic [USER_W-1:0]       r_user;

    assign en       = !r_ov || i_tready;
    assign o_pop    = i_valid && en;
    assign o_tvalid = r_ov;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

    // operand prep: magnitudes, sign and early overflow test
    always_comb begin
        w_det = $signed(i_job.det);
        w_div = (w_det == 64'sd0) ? Q_ONE : w_det;
        w_dv  = w_div[63] ? 64'(-w_div) : w_div;
        for (int k = 0; k < NE; k++) begin
            w_num[k] = {i_job.cof[k], 16'd0};
            w_n[k]   = w_num[k][63] ? -w_num[k] : w_num[k];
            w_neg[k] = w_num[k][63] ^ w_div[63];
            w_ovf[k] = {32'd0, w_n[k][63:32]} >= w_dv;
        end
    end

    // restoring step: stage s decides quotient bit DIV_STG-s
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n_rem[0][k] = r_rem[0][k];
            n_quo[0][k] = r_quo[0][k];
        end
        for (int s = 1; s <= DIV_STG; s++) begin
            for (int k = 0; k < NE; k++) begin
                if ((r_rem[s-1][k] >> (DIV_STG - s)) >= r_dv[s-1]) begin
                    n_rem[s][k] = r_rem[s-1][k] - (r_dv[s-1] << (DIV_STG - s));
                    n_quo[s][k] = r_quo[s-1][k] | (32'd1 << (DIV_STG - s));
                end else begin
                    n_rem[s][k] = r_rem[s-1][k];
                    n_quo[s][k] = r_quo[s-1][k];
                end
            end
        end
    end

    // sign and clamp
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n_sat[k] = 1'b0;
            if (r_ovf[DIV_STG][k]) begin
                n_sat[k] = 1'b1;
                n_data[ELEM_W*k +: ELEM_W] = r_neg[DIV_STG][k] ? 32'h8000_0000
                                                                : 32'h7FFF_FFFF;
            end else if (r_neg[DIV_STG][k]) begin
                n_sat[k] = r_quo[DIV_STG][k] > 32'h8000_0000;
                n_data[ELEM_W*k +: ELEM_W] = n_sat[k] ? 32'h8000_0000
                                                      : -r_quo[DIV_STG][k];
            end else begin
                n_sat[k] = r_quo[DIV_STG][k][31];
                n_data[ELEM_W*k +: ELEM_W] = n_sat[k] ? 32'h7FFF_FFFF
                                                      : r_quo[DIV_STG][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[DIV_STG-1:0], i_valid};
            r_ov <= r_v[DIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0]   <= w_dv;
            r_sing[0] <= (w_det == 64'sd0);
            for (int k = 0; k < NE; k++) begin
                r_rem[0][k] <= w_n[k];
                r_quo[0][k] <= '0;
                r_neg[0][k] <= w_neg[k];
                r_ovf[0][k] <= w_ovf[k];
            end
            for (int s = 1; s <= DIV_STG; s++) begin
                r_dv[s]   <= r_dv[s-1];
                r_sing[s] <= r_sing[s-1];
                for (int k = 0; k < NE; k++) begin
                    r_rem[s][k] <= n_rem[s][k];
                    r_quo[s][k] <= n_quo[s][k];
                    r_neg[s][k] <= r_neg[s-1][k];
                    r_ovf[s][k] <= r_ovf[s-1][k];
                end
            end
            r_data           <= n_data;
            r_user[USER_SING] <= r_sing[DIV_STG];
            r_user[USER_SAT]  <= |n_sat;
        end
    end

endmodule
